// ===== hw/rtl/krtp_pkg.sv =====
// Shared types and constants for the keyed record text parser.
// Holds character codes, result kind codes and the input stage word struct.
// No dependencies; compile first.
`timescale 1ns / 1ps

package krtp_pkg;

    // Payload field widths fixed by the word formats.
    localparam int TEXT_BITS   = 8;
    localparam int VALUE_BITS  = 64;
    localparam int DIGITS_BITS = 8;
    localparam int LENGTH_BITS = 16;

    // Result kind codes.
    typedef enum logic [1:0] {
        KIND_STRING_CHAR = 2'd0,
        KIND_COMPLETE    = 2'd1,
        KIND_REJECT      = 2'd2
    } kind_t;

    // Character codes used by the grammar.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_K  = 8'h6B;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_Y  = 8'h79;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_UP_B   = 8'h42;

    // One registered input word as handed from the input stage to the parser.
    typedef struct packed {
        logic                  valid;
        logic [TEXT_BITS-1:0]  text_byte;
        logic                  line_end;
    } krtp_item_t;

endpackage

// ===== hw/rtl/krtp_if.sv =====
// Channel interfaces for the keyed record text parser: text input and result output.
// Each carries valid, ready and the payload. Depends on krtp_pkg.
`timescale 1ns / 1ps

interface krtp_in_if
    import krtp_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [TEXT_BITS-1:0] text_byte;
    logic                 line_end;

    modport source (output valid, output text_byte, output line_end, input ready);
    modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface krtp_out_if
    import krtp_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    kind_t                  kind;
    logic [TEXT_BITS-1:0]   string_char;
    logic [VALUE_BITS-1:0]  decimal_value;
    logic [VALUE_BITS-1:0]  binary_value;
    logic [DIGITS_BITS-1:0] binary_digits;
    logic [LENGTH_BITS-1:0] string_length;

    modport source (
        output valid, output kind, output string_char, output decimal_value,
        output binary_value, output binary_digits, output string_length,
        input ready
    );
    modport sink (
        input valid, input kind, input string_char, input decimal_value,
        input binary_value, input binary_digits, input string_length,
        output ready
    );
endinterface

// ===== hw/rtl/keyed_record_text_parser.sv =====
// Keyed record text parser, top level.
// A text word that yields a result passes through the input register stage and then the result register.
// Throughput: one text word per cycle, limited only by the result side's ready.
// Reset (rst_n low, asynchronous): parser idle, accumulators and key state cleared,
// both the input stage and the result register empty.
`timescale 1ns / 1ps

// The block reads records of the form (:key1 N ull:key2 0bBITS:key3 "TEXT":)
// with the three fields in any order, each key once. Leading whitespace is
// skipped only between records. Every character inside the quoted string is
// passed out as a string-character word as soon as it is parsed; a closing
// parenthesis produces one record-complete word with the decimal value, the
// binary value, the binary digit count and the string length. The first error
// on a line produces one reject word, and everything up to the line end is
// ignored. A line end inside an open record also produces a reject word.
//
// Structure: an input register stage holds one text word; the parser core
// decides the next phase and the result combinationally and writes the
// result register. The input stage reloads whenever its word moves on; while a
// finished result waits to be taken, the block stops taking words.
// STRING_COUNT_BITS and DIGIT_COUNT_BITS set where the string length and the
// binary digit count saturate; the reported fields are their low bits.

module keyed_record_text_parser
    import krtp_pkg::*;
#(
    parameter int STRING_COUNT_BITS = 16,
    parameter int DIGIT_COUNT_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    krtp_in_if.sink     text_in,
    krtp_out_if.source  record_out
);

    krtp_item_t item;
    logic       advance;

    // Input register stage.
    krtp_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .advance (advance),
        .item    (item)
    );

    // Parser state and result register.
    krtp_core #(
        .STRING_COUNT_BITS (STRING_COUNT_BITS),
        .DIGIT_COUNT_BITS  (DIGIT_COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .record_out (record_out)
    );

endmodule

// ===== hw/rtl/krtp_in_stage.sv =====
// Input register stage of the keyed record text parser.
// Captures one text word per cycle and holds it until the parser takes it.
// Depends on krtp_pkg and krtp_if.
`timescale 1ns / 1ps

module krtp_in_stage
    import krtp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    krtp_in_if.sink       text_in,
    input  logic          advance,
    output krtp_item_t    item
);

    logic                 valid_reg;
    logic [TEXT_BITS-1:0] byte_reg;
    logic                 eol_reg;

    // The stage may load whenever it is empty or its word moves on this cycle.
    assign text_in.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            byte_reg <= text_in.text_byte;
            eol_reg  <= text_in.line_end;
        end
    end

    assign item.valid     = valid_reg;
    assign item.text_byte = byte_reg;
    assign item.line_end  = eol_reg;

endmodule

// ===== hw/rtl/krtp_core.sv =====
// Parser core of the keyed record text parser: phase register, accumulators,
// key tracking and the result register. Depends on krtp_pkg and krtp_if.
`timescale 1ns / 1ps

module krtp_core
    import krtp_pkg::*;
#(
    parameter int STRING_COUNT_BITS = 16,
    parameter int DIGIT_COUNT_BITS  = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  krtp_item_t   item,
    output logic         advance,
    krtp_out_if.source   record_out
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_OPEN_COLON, PH_KEY_K, PH_KEY_E, PH_KEY_Y, PH_KEY_NUM,
        PH_KEY_SPACE, PH_DEC_FIRST, PH_DEC_MORE, PH_DEC_L1, PH_DEC_L2,
        PH_BIN_ZERO, PH_BIN_B, PH_BIN_DIGITS, PH_STR_QUOTE, PH_STR_BODY,
        PH_DELIM, PH_CLOSE, PH_DROP
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [VALUE_BITS-1:0]        dec_reg, dec_next;
    logic [VALUE_BITS-1:0]        bin_reg, bin_next;
    logic [DIGIT_COUNT_BITS-1:0]  digits_reg, digits_next;
    logic [STRING_COUNT_BITS-1:0] length_reg, length_next;
    logic [2:0]                   seen_reg, seen_next;
    logic [1:0]                   done_reg, done_next;
    logic [1:0]                   pend_reg, pend_next;

    logic                         out_valid_reg, out_valid_next;
    kind_t                        kind_reg, kind_next;
    logic [TEXT_BITS-1:0]         char_reg, char_next;
    logic [VALUE_BITS-1:0]        dec_out_reg, dec_out_next;
    logic [VALUE_BITS-1:0]        bin_out_reg, bin_out_next;
    logic [DIGITS_BITS-1:0]       digits_out_reg, digits_out_next;
    logic [LENGTH_BITS-1:0]       length_out_reg, length_out_next;

    logic                         fire;
    logic [TEXT_BITS-1:0]         c;
    logic                         c_space;
    logic                         c_dec_digit;
    logic [1:0]                   key_bit;
    logic [1:0]                   done_inc;
    logic [31:0]                  digits_wide;
    logic [31:0]                  length_wide;

    assign advance     = !out_valid_reg || record_out.ready;
    assign fire        = item.valid && advance;
    assign c           = item.text_byte;
    assign c_space     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign c_dec_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign key_bit     = 2'(c[1:0] - 2'd1);
    assign done_inc    = 2'(done_reg + 2'd1);
    assign digits_wide = 32'(digits_reg);
    assign length_wide = 32'(length_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        dec_next        = dec_reg;
        bin_next        = bin_reg;
        digits_next     = digits_reg;
        length_next     = length_reg;
        seen_next       = seen_reg;
        done_next       = done_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !record_out.ready;
        kind_next       = kind_reg;
        char_next       = char_reg;
        dec_out_next    = dec_out_reg;
        bin_out_next    = bin_out_reg;
        digits_out_next = digits_out_reg;
        length_out_next = length_out_reg;

        if (fire)
        begin
            // Any word taken into the result register starts with zero payload.
            kind_next       = KIND_REJECT;
            char_next       = '0;
            dec_out_next    = '0;
            bin_out_next    = '0;
            digits_out_next = '0;
            length_out_next = '0;

            if (item.line_end)
            begin
                phase_next  = PH_IDLE;
                dec_next    = '0;
                bin_next    = '0;
                digits_next = '0;
                length_next = '0;
                seen_next   = '0;
                done_next   = '0;
                pend_next   = '0;
                // An open record is rejected; idle or dropped lines end quietly.
                out_valid_next = (phase_reg != PH_IDLE) && (phase_reg != PH_DROP);
            end
            else
            begin
                // A reject leaves kind as set above and drops the rest of the line.
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (!c_space)
                        begin
                            if (c == CH_LPAREN)
                            begin
                                phase_next  = PH_OPEN_COLON;
                                dec_next    = '0;
                                bin_next    = '0;
                                digits_next = '0;
                                length_next = '0;
                                seen_next   = '0;
                                done_next   = '0;
                                pend_next   = '0;
                            end
                            else
                            begin
                                phase_next     = PH_DROP;
                                out_valid_next = 1'b1;
                            end
                        end
                    end
                    PH_OPEN_COLON, PH_KEY_K, PH_KEY_E, PH_KEY_Y,
                    PH_DEC_L1, PH_DEC_L2, PH_BIN_ZERO, PH_BIN_B,
                    PH_STR_QUOTE, PH_DELIM:
                    begin
                        phase_next     = PH_DROP;
                        out_valid_next = 1'b1;
                        unique case (phase_reg)
                            PH_OPEN_COLON:
                                if (c == CH_COLON)
                                begin
                                    phase_next = PH_KEY_K;
                                    out_valid_next = 1'b0;
                                end
                            PH_KEY_K:
                                if (c == CH_LOW_K)
                                begin
                                    phase_next = PH_KEY_E;
                                    out_valid_next = 1'b0;
                                end
                            PH_KEY_E:
                                if (c == CH_LOW_E)
                                begin
                                    phase_next = PH_KEY_Y;
                                    out_valid_next = 1'b0;
                                end
                            PH_KEY_Y:
                                if (c == CH_LOW_Y)
                                begin
                                    phase_next = PH_KEY_NUM;
                                    out_valid_next = 1'b0;
                                end
                            PH_DEC_L1:
                                if (c == CH_LOW_L || c == CH_UP_L)
                                begin
                                    phase_next = PH_DEC_L2;
                                    out_valid_next = 1'b0;
                                end
                            PH_DEC_L2:
                                if (c == CH_LOW_L || c == CH_UP_L)
                                begin
                                    phase_next = PH_DELIM;
                                    out_valid_next = 1'b0;
                                end
                            PH_BIN_ZERO:
                                if (c == CH_ZERO)
                                begin
                                    phase_next = PH_BIN_B;
                                    out_valid_next = 1'b0;
                                end
                            PH_BIN_B:
                                if (c == CH_LOW_B || c == CH_UP_B)
                                begin
                                    phase_next = PH_BIN_DIGITS;
                                    out_valid_next = 1'b0;
                                end
                            PH_STR_QUOTE:
                                if (c == CH_QUOTE)
                                begin
                                    phase_next = PH_STR_BODY;
                                    out_valid_next = 1'b0;
                                end
                            default:
                                // Field delimiter: the third one leads to the close.
                                if (c == CH_COLON)
                                begin
                                    done_next      = done_inc;
                                    phase_next     = (done_inc == 2'd3) ? PH_CLOSE : PH_KEY_K;
                                    out_valid_next = 1'b0;
                                end
                        endcase
                    end
                    PH_KEY_NUM:
                    begin
                        if (c >= CH_ONE && c <= CH_THREE && !seen_reg[key_bit])
                        begin
                            pend_next  = c[1:0];
                            phase_next = PH_KEY_SPACE;
                        end
                        else
                        begin
                            phase_next     = PH_DROP;
                            out_valid_next = 1'b1;
                        end
                    end
                    PH_KEY_SPACE:
                    begin
                        if (c == CH_SPACE)
                        begin
                            seen_next[2'(pend_reg - 2'd1)] = 1'b1;
                            priority case (pend_reg)
                                2'd1:    phase_next = PH_DEC_FIRST;
                                2'd2:    phase_next = PH_BIN_ZERO;
                                default: phase_next = PH_STR_QUOTE;
                            endcase
                        end
                        else
                        begin
                            phase_next     = PH_DROP;
                            out_valid_next = 1'b1;
                        end
                    end
                    PH_DEC_FIRST, PH_DEC_MORE:
                    begin
                        if (c_dec_digit)
                        begin
                            dec_next   = (dec_reg << 3) + (dec_reg << 1)
                                         + VALUE_BITS'(c[3:0]);
                            phase_next = PH_DEC_MORE;
                        end
                        else if (phase_reg == PH_DEC_MORE
                                 && (c == CH_LOW_U || c == CH_UP_U))
                        begin
                            phase_next = PH_DEC_L1;
                        end
                        else
                        begin
                            phase_next     = PH_DROP;
                            out_valid_next = 1'b1;
                        end
                    end
                    PH_BIN_DIGITS:
                    begin
                        if (c == CH_ZERO || c == CH_ONE)
                        begin
                            bin_next = {bin_reg[VALUE_BITS-2:0], c[0]};
                            if (digits_reg != '1)
                            begin
                                digits_next = DIGIT_COUNT_BITS'(digits_reg + 1'b1);
                            end
                        end
                        else if (digits_reg != '0 && c == CH_COLON)
                        begin
                            // This colon closes the binary field.
                            done_next  = done_inc;
                            phase_next = (done_inc == 2'd3) ? PH_CLOSE : PH_KEY_K;
                        end
                        else
                        begin
                            phase_next     = PH_DROP;
                            out_valid_next = 1'b1;
                        end
                    end
                    PH_STR_BODY:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            phase_next = PH_DELIM;
                        end
                        else
                        begin
                            if (length_reg != '1)
                            begin
                                length_next = STRING_COUNT_BITS'(length_reg + 1'b1);
                            end
                            kind_next      = KIND_STRING_CHAR;
                            char_next      = c;
                            out_valid_next = 1'b1;
                        end
                    end
                    PH_CLOSE:
                    begin
                        out_valid_next = 1'b1;
                        if (c == CH_RPAREN)
                        begin
                            phase_next      = PH_IDLE;
                            kind_next       = KIND_COMPLETE;
                            dec_out_next    = dec_reg;
                            bin_out_next    = bin_reg;
                            digits_out_next = digits_wide[DIGITS_BITS-1:0];
                            length_out_next = length_wide[LENGTH_BITS-1:0];
                        end
                        else
                        begin
                            phase_next = PH_DROP;
                        end
                    end
                    default:
                    begin
                        // Dropped line, or an unused phase code: wait for line end.
                        phase_next = PH_DROP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            dec_reg       <= '0;
            bin_reg       <= '0;
            digits_reg    <= '0;
            length_reg    <= '0;
            seen_reg      <= '0;
            done_reg      <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            dec_reg       <= dec_next;
            bin_reg       <= bin_next;
            digits_reg    <= digits_next;
            length_reg    <= length_next;
            seen_reg      <= seen_next;
            done_reg      <= done_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        char_reg       <= char_next;
        dec_out_reg    <= dec_out_next;
        bin_out_reg    <= bin_out_next;
        digits_out_reg <= digits_out_next;
        length_out_reg <= length_out_next;
    end

    assign record_out.valid         = out_valid_reg;
    assign record_out.kind          = kind_reg;
    assign record_out.string_char   = char_reg;
    assign record_out.decimal_value = dec_out_reg;
    assign record_out.binary_value  = bin_out_reg;
    assign record_out.binary_digits = digits_out_reg;
    assign record_out.string_length = length_out_reg;

endmodule
